>>> rtl/core/zer_pkg.sv
`default_nettype none

package zer_pkg;

    // Fixed field widths
    localparam int MASK_W    = 9;
    localparam int FRAME_LEN = 5;
    localparam int CNT_W     = 3;
    localparam int GRP_W     = 4;

    localparam int DEFAULT_NUM_EXPANDERS = 9;

    // Bus addressing
    localparam int BASE_ADDR     = 7;   // entry 0 answers at this address
    localparam int NORM_SHIFT    = 6;   // normal mode: select bit = address - 6
    localparam int EXT_SHIFT     = 13;  // extended mode: select bit = address - 13

    // Function codes
    localparam logic FUNC_POLL = 1'b0;
    localparam logic FUNC_ZONE = 1'b1;

    // Poll types
    localparam logic [7:0] TYPE_ZONE_STATUS = 8'hF1;
    localparam logic [7:0] TYPE_OPEN_BITS   = 8'hF7;
    localparam logic [7:0] TYPE_RELAY       = 8'h00;
    localparam logic [7:0] TYPE_RELAY_EXT   = 8'h0D;

    // Reply constants
    localparam logic [7:0] SEQ_FIRST    = 8'h20;
    localparam logic [7:0] SEQR_FIRST   = 8'h31;
    localparam logic [7:0] SEQR_OTHER   = 8'h34;
    localparam logic [7:0] OPEN_BITS_ID = 8'hF0;

    // Zone range that maps onto expander groups
    localparam logic [5:0] ZONE_MIN = 6'd9;
    localparam logic [5:0] ZONE_MAX = 6'd48;

    typedef struct packed {
        logic       func;
        logic [7:0] device_byte;
        logic [7:0] byte_three;
        logic [7:0] byte_four;
        logic [7:0] byte_five;
        logic [7:0] byte_six;
        logic [5:0] zone_number;
        logic       zone_open;
    } req_t;

    // Reply frame, byte 0 goes out first
    typedef struct packed {
        logic                          hit;
        logic [FRAME_LEN-1:0][7:0]     bytes;
    } frame_t;

endpackage

`default_nettype wire

>>> rtl/core/zer_zone_store.sv
`default_nettype none

module zer_zone_store #(
    parameter int NUM_EXPANDERS = zer_pkg::DEFAULT_NUM_EXPANDERS,
    parameter int IDX_W         = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ev_we,
    input  wire logic [5:0]        zone_number,
    input  wire logic              zone_open,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic [7:0]             zone_code,
    output logic [7:0]             open_bits
);
    import zer_pkg::*;

    logic [7:0]       zone_code_reg [NUM_EXPANDERS];
    logic [7:0]       open_bits_reg [NUM_EXPANDERS];
    logic             in_range;
    logic [5:0]       zoff;
    logic [GRP_W-1:0] grp;
    logic [2:0]       zsub;
    logic [7:0]       code_new;
    logic [7:0]       bit_mask;

    always_comb
    begin
        in_range = (zone_number >= ZONE_MIN) && (zone_number <= ZONE_MAX);
        zoff     = zone_number - ZONE_MIN;
        grp      = {1'b0, zoff[5:3]};
        zsub     = zone_number[2:0];
        code_new = {zsub, 1'b0, zone_open, 3'b000};
        // zone 0 of a group is its top zone and sits in bit 0
        if (zsub == 3'd0)
            bit_mask = 8'h01;
        else
            bit_mask = 8'h80 >> (zsub - 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_EXPANDERS; i++)
            begin
                zone_code_reg[i] <= 8'h00;
                open_bits_reg[i] <= 8'h00;
            end
        end
        else if (ev_we && in_range)
        begin
            for (int i = 0; i < NUM_EXPANDERS; i++)
            begin
                if (grp == GRP_W'(i))
                begin
                    zone_code_reg[i] <= code_new;
                    if (zone_open)
                        open_bits_reg[i] <= open_bits_reg[i] | bit_mask;
                    else
                        open_bits_reg[i] <= open_bits_reg[i] & ~bit_mask;
                end
            end
        end
    end

    assign zone_code = zone_code_reg[rd_idx];
    assign open_bits = open_bits_reg[rd_idx];

endmodule

`default_nettype wire

>>> rtl/core/zer_frame_build.sv
`default_nettype none

module zer_frame_build #(
    parameter int NUM_EXPANDERS = zer_pkg::DEFAULT_NUM_EXPANDERS,
    parameter int IDX_W         = 4
) (
    input  wire zer_pkg::req_t              req,
    input  wire logic [zer_pkg::MASK_W-1:0] enable_mask,
    input  wire logic [7:0]                 zone_code,
    input  wire logic [7:0]                 open_bits,
    output logic [IDX_W-1:0]                rd_idx,
    output zer_pkg::frame_t                 frame
);
    import zer_pkg::*;

    logic [NUM_EXPANDERS-1:0] match;
    logic                     ext;
    logic                     found;
    logic                     known;
    logic [7:0]               seq;
    logic [7:0]               kind;
    logic [7:0]               relay;
    logic [7:0]               addr_byte;
    logic [7:0]               b0;
    logic [7:0]               b3;
    logic [7:0]               seqr;
    logic [9:0]               sum;

    assign ext = req.device_byte[0];

    // per-entry select decode
    always_comb
    begin
        for (int i = 0; i < NUM_EXPANDERS; i++)
        begin
            match[i] = 1'b0;
            if (enable_mask[i])
            begin
                if (ext)
                begin
                    if ((i + BASE_ADDR >= EXT_SHIFT) && (i + BASE_ADDR - EXT_SHIFT <= 7))
                        match[i] = (req.device_byte
                                    == 8'(1 << (i + BASE_ADDR - EXT_SHIFT)));
                end
                else
                begin
                    if (i + BASE_ADDR - NORM_SHIFT <= 7)
                        match[i] = (req.device_byte
                                    == 8'(1 << (i + BASE_ADDR - NORM_SHIFT)));
                end
            end
        end
    end

    // lowest entry wins
    always_comb
    begin
        found  = 1'b0;
        rd_idx = '0;
        for (int i = 0; i < NUM_EXPANDERS; i++)
        begin
            if (!found && match[i])
            begin
                found  = 1'b1;
                rd_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        seq   = ext ? req.byte_four : req.byte_three;
        kind  = ext ? req.byte_five : req.byte_four;
        relay = ext ? req.byte_six  : req.byte_five;
        seqr  = (seq == SEQ_FIRST) ? SEQR_FIRST : SEQR_OTHER;
        addr_byte = 8'(rd_idx) + 8'(BASE_ADDR);

        unique case (kind) inside
            TYPE_ZONE_STATUS:
            begin
                known = 1'b1;
                b0    = addr_byte;
                b3    = zone_code;
            end
            TYPE_OPEN_BITS:
            begin
                known = 1'b1;
                b0    = OPEN_BITS_ID;
                b3    = open_bits;
            end
            TYPE_RELAY, TYPE_RELAY_EXT:
            begin
                known = 1'b1;
                b0    = addr_byte;
                b3    = relay;
            end
            default:
            begin
                known = 1'b0;
                b0    = addr_byte;
                b3    = relay;
            end
        endcase

        sum = {2'b00, b0} + {2'b00, seqr} + {2'b00, b3};

        frame.hit      = found && known;
        frame.bytes[0] = b0;
        frame.bytes[1] = seqr;
        frame.bytes[2] = 8'h00;
        frame.bytes[3] = b3;
        frame.bytes[4] = ~(sum[7:0] - 8'd1);
    end

endmodule

`default_nettype wire

>>> rtl/core/zer_reply_ser.sv
`default_nettype none

module zer_reply_ser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire logic [zer_pkg::FRAME_LEN-1:0][7:0] load_bytes,
    output logic                               load_ok,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [7:0]                         reply_byte,
    output logic                               reply_last
);
    import zer_pkg::*;

    logic                      busy_reg;
    logic                      busy_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic [FRAME_LEN-1:0][7:0] data_reg;
    logic [FRAME_LEN-1:0][7:0] data_next;
    logic                      take;
    logic                      at_last;

    assign at_last = (cnt_reg == CNT_W'(FRAME_LEN - 1));
    assign take    = busy_reg && out_ready;
    // a new frame may land in the cycle the checksum leaves
    assign load_ok = !busy_reg || (take && at_last);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (take)
        begin
            if (at_last)
                busy_next = 1'b0;
            cnt_next  = cnt_reg + CNT_W'(1);
            data_next = {8'h00, data_reg[FRAME_LEN-1:1]};
        end
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            data_next = load_bytes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid  = busy_reg;
    assign reply_byte = data_reg[0];
    assign reply_last = at_last;

endmodule

`default_nettype wire

>>> rtl/core/zone_expander_responder_core.sv
`default_nettype none

// Channel  | Handshake             | Carries
// ---------+-----------------------+----------------------------------------------
// in       | in_valid / in_ready   | one request: poll packet or zone event
// out      | out_valid / out_ready | one reply byte, reply_last on the checksum
// cfg      | cfg_valid / cfg_ready | expander_enable_mask (always ready)
//
// A request is registered, then handled: a zone event updates the
// zone store, a poll builds its five-byte frame and hands it to the serializer.
// The serializer sends one byte per cycle while out_ready is high, so a poll
// that answers waits until the previous frame's checksum has left; events
// and unanswered polls go through at one per cycle. Output stalls back up
// into the input register; reset clears the store, the mask and all valid state.

module zone_expander_responder_core #(
    parameter int NUM_EXPANDERS = zer_pkg::DEFAULT_NUM_EXPANDERS
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      func,
    input  wire logic [7:0]                device_byte,
    input  wire logic [7:0]                byte_three,
    input  wire logic [7:0]                byte_four,
    input  wire logic [7:0]                byte_five,
    input  wire logic [7:0]                byte_six,
    input  wire logic [5:0]                zone_number,
    input  wire logic                      zone_open,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     reply_byte,
    output logic                           reply_last,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [zer_pkg::MASK_W-1:0] cfg_data
);
    import zer_pkg::*;

    localparam int IDX_W = (NUM_EXPANDERS > 1) ? $clog2(NUM_EXPANDERS) : 1;

    logic [MASK_W-1:0] mask_reg;
    logic              s1_valid_reg;
    req_t              s1_req_reg;
    req_t              in_req;
    logic              is_event;
    logic              s1_advance;
    logic              ser_load;
    logic              load_ok;
    logic [IDX_W-1:0]  rd_idx;
    logic [7:0]        rd_zone_code;
    logic [7:0]        rd_open_bits;
    frame_t            frame;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (cfg_valid)
            mask_reg <= cfg_data;
    end

    assign in_req = '{
        func:        func,
        device_byte: device_byte,
        byte_three:  byte_three,
        byte_four:   byte_four,
        byte_five:   byte_five,
        byte_six:    byte_six,
        zone_number: zone_number,
        zone_open:   zone_open
    };

    // Request register stage
    assign is_event   = (s1_req_reg.func == FUNC_ZONE);
    // events and polls with no answer never wait on the serializer
    assign s1_advance = s1_valid_reg && (is_event || !frame.hit || load_ok);
    assign ser_load   = s1_valid_reg && !is_event && frame.hit && load_ok;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_req_reg <= in_req;
    end

    zer_zone_store #(
        .NUM_EXPANDERS (NUM_EXPANDERS),
        .IDX_W         (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .ev_we       (s1_valid_reg && is_event),
        .zone_number (s1_req_reg.zone_number),
        .zone_open   (s1_req_reg.zone_open),
        .rd_idx      (rd_idx),
        .zone_code   (rd_zone_code),
        .open_bits   (rd_open_bits)
    );

    zer_frame_build #(
        .NUM_EXPANDERS (NUM_EXPANDERS),
        .IDX_W         (IDX_W)
    ) u_build (
        .req         (s1_req_reg),
        .enable_mask (mask_reg),
        .zone_code   (rd_zone_code),
        .open_bits   (rd_open_bits),
        .rd_idx      (rd_idx),
        .frame       (frame)
    );

    zer_reply_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (ser_load),
        .load_bytes (frame.bytes),
        .load_ok    (load_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .reply_byte (reply_byte),
        .reply_last (reply_last)
    );

endmodule

`default_nettype wire
